/* src/mg3_pkg.sv */
// Shared types and constants for the masked 3x3 Gaussian RGB blur.
// Holds the pixel and result transaction structs, the sequencer states
// and the kernel weight lookup. No dependencies.
`default_nettype none

package mg3_pkg;

  // Channel width of an incoming pixel
  localparam int PIXEL_BITS = 8;
  // Weighted channel sum: nine pixels, weights total 16
  localparam int SUM_W = PIXEL_BITS + 4;
  // Result channel width
  localparam int OUT_W = 12;
  // Counted weight total, at most 16
  localparam int TOT_W = 5;
  // Position inside the 3x3 window
  localparam int POS_W = 4;
  // Bit counter of the serial divider
  localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  // Channel codes for the divider pass
  localparam logic [1:0] CH_RED  = 2'd0;
  localparam logic [1:0] CH_BLUE = 2'd2;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] blue_in;
    logic [PIXEL_BITS-1:0] green_in;
    logic [PIXEL_BITS-1:0] red_in;
  } pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic             zero_weight;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  // Kernel 1 2 1 / 2 4 2 / 1 2 1 as a left-shift amount.
  // Positions past the end act as the last tap (weight 1).
  function automatic logic [1:0] kernel_shift(input logic [POS_W-1:0] pos);
    logic [1:0] sh;
    case (pos) inside
      4'd4: begin
        sh = 2'd2;
      end
      4'd1, 4'd3, 4'd5, 4'd7: begin
        sh = 2'd1;
      end
      default: begin
        sh = 2'd0;
      end
    endcase
    return sh;
  endfunction

endpackage

`default_nettype wire

/* src/masked_gauss_3x3_rgb_top.sv */
// After a window's ninth pixel is accepted, three serial divisions (one per channel,
// a load step and then one step per quotient bit) run before the result is registered.
// Throughput: one pixel per cycle for the first eight pixels; the ninth starts
// the shared restoring divider, and no pixel is taken until its result is latched.
// Reset (rst, synchronous): clears accumulators, window position and output valid.
// Masked 3x3 Gaussian blur of RGB pixels; uses mg3_pkg.
`default_nettype none

module masked_gauss_3x3_rgb_top (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pix_valid,
  output logic                 pix_ready,
  input  wire mg3_pkg::pixel_t pix,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output mg3_pkg::result_t     res
);

  mg3_pkg::state_t state;
  mg3_pkg::state_t state_next;

  // Window accumulators
  logic [mg3_pkg::SUM_W-1:0] sum [3];
  logic [mg3_pkg::SUM_W-1:0] sum_acc [3];
  logic [mg3_pkg::TOT_W-1:0] total;
  logic [mg3_pkg::POS_W-1:0] pos;

  // Serial divider state
  logic [1:0]                ch;
  logic [mg3_pkg::CNT_W-1:0] bit_cnt;
  logic [mg3_pkg::TOT_W-1:0] rem;
  logic [mg3_pkg::SUM_W-1:0] dq;

  logic [1:0]                sh;
  logic                      pix_counted;
  logic                      pos_last;
  logic [mg3_pkg::TOT_W-1:0] weight;
  logic [mg3_pkg::TOT_W:0]   trial;
  logic                      quo_bit;
  logic [mg3_pkg::TOT_W-1:0] rem_step;
  logic [mg3_pkg::SUM_W-1:0] dq_step;
  logic                      bit_last;
  logic                      out_free;
  logic                      pix_take;

  // Per-pixel weighted accumulate
  always_comb begin
    sh          = mg3_pkg::kernel_shift(pos);
    pos_last    = pos[mg3_pkg::POS_W-1];
    weight      = mg3_pkg::TOT_W'(1) << sh;
    pix_counted = (pix.red_in != '0) && (pix.green_in != '0) && (pix.blue_in != '0);
    sum_acc[0]  = sum[0] + (mg3_pkg::SUM_W'(pix.red_in) << sh);
    sum_acc[1]  = sum[1] + (mg3_pkg::SUM_W'(pix.green_in) << sh);
    sum_acc[2]  = sum[2] + (mg3_pkg::SUM_W'(pix.blue_in) << sh);
  end

  // Restoring divider step: one quotient bit per cycle
  always_comb begin
    trial    = {rem, dq[mg3_pkg::SUM_W-1]};
    quo_bit  = (trial >= {1'b0, total});
    rem_step = quo_bit ? mg3_pkg::TOT_W'(trial - {1'b0, total})
                       : trial[mg3_pkg::TOT_W-1:0];
    dq_step  = {dq[mg3_pkg::SUM_W-2:0], quo_bit};
    bit_last = (bit_cnt == mg3_pkg::CNT_W'(mg3_pkg::SUM_W - 1));
  end

  assign out_free = !res_valid || res_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mg3_pkg::ST_IDLE: begin
        if (pix_valid && pos_last) state_next = mg3_pkg::ST_LOAD;
      end
      mg3_pkg::ST_LOAD: begin
        state_next = mg3_pkg::ST_DIV;
      end
      mg3_pkg::ST_DIV: begin
        if (bit_last) begin
          state_next = (ch == mg3_pkg::CH_BLUE) ? mg3_pkg::ST_DONE : mg3_pkg::ST_LOAD;
        end
      end
      mg3_pkg::ST_DONE: begin
        if (out_free) state_next = mg3_pkg::ST_IDLE;
      end
      default: begin
        state_next = mg3_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    pix_ready = 1'b0;
    unique case (state)
      mg3_pkg::ST_IDLE: pix_ready = 1'b1;
      mg3_pkg::ST_LOAD: pix_ready = 1'b0;
      mg3_pkg::ST_DIV:  pix_ready = 1'b0;
      mg3_pkg::ST_DONE: pix_ready = 1'b0;
      default:          pix_ready = 1'b0;
    endcase
  end

  assign pix_take = pix_valid && pix_ready;

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mg3_pkg::ST_IDLE;
      pos       <= '0;
      total     <= '0;
      sum[0]    <= '0;
      sum[1]    <= '0;
      sum[2]    <= '0;
      ch        <= mg3_pkg::CH_RED;
      bit_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      // in the done state the output register is reloaded instead
      if (res_valid && res_ready && state != mg3_pkg::ST_DONE) res_valid <= 1'b0;

      case (state)
        mg3_pkg::ST_IDLE: begin
          if (pix_take) begin
            sum[0] <= sum_acc[0];
            sum[1] <= sum_acc[1];
            sum[2] <= sum_acc[2];
            if (pix_counted) total <= total + weight;
            if (!pos_last) pos <= pos + 1'b1;
            ch <= mg3_pkg::CH_RED;
          end
        end
        mg3_pkg::ST_LOAD: begin
          dq      <= sum[ch];
          rem     <= '0;
          bit_cnt <= '0;
        end
        mg3_pkg::ST_DIV: begin
          dq      <= dq_step;
          rem     <= rem_step;
          bit_cnt <= bit_cnt + 1'b1;
          // quotient replaces the channel sum
          if (bit_last) begin
            sum[ch] <= dq_step;
            ch      <= ch + 1'b1;
          end
        end
        mg3_pkg::ST_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            if (total == '0) begin
              res.red_out     <= '0;
              res.green_out   <= '0;
              res.blue_out    <= '0;
              res.zero_weight <= 1'b1;
            end else begin
              res.red_out     <= mg3_pkg::OUT_W'(sum[0]);
              res.green_out   <= mg3_pkg::OUT_W'(sum[1]);
              res.blue_out    <= mg3_pkg::OUT_W'(sum[2]);
              res.zero_weight <= 1'b0;
            end
            // clear window for the next one
            sum[0] <= '0;
            sum[1] <= '0;
            sum[2] <= '0;
            total  <= '0;
            pos    <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* verif/masked_gauss_3x3_rgb_check.sv */
// Checker for the masked 3x3 Gaussian RGB blur: watches the pixel and result
// channels, predicts each window result and compares it with what the block emits.
// Depends on mg3_pkg for the pixel and result transaction types.
module masked_gauss_3x3_rgb_check (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_valid,
  input  logic             pix_ready,
  input  mg3_pkg::pixel_t  pix,
  input  logic             res_valid,
  input  logic             res_ready,
  input  mg3_pkg::result_t res,
  output int               fail_count,
  output int               pending
);

  localparam int MAX_REPORTS = 10;
  // Blur kernel in raster order
  localparam int TAP_WEIGHT [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

  // Running window state of the prediction
  logic [mg3_pkg::SUM_W-1:0] red_acc;
  logic [mg3_pkg::SUM_W-1:0] green_acc;
  logic [mg3_pkg::SUM_W-1:0] blue_acc;
  logic [mg3_pkg::TOT_W-1:0] counted_weight;
  logic [mg3_pkg::POS_W-1:0] tap_pos;

  mg3_pkg::result_t expected_blurs [$];
  int               failures;

  task automatic clear_window();
    red_acc = '0;
    green_acc = '0;
    blue_acc = '0;
    counted_weight = '0;
    tap_pos = '0;
  endtask

  // Fold one pixel into the window; the last tap yields the blurred pixel
  task automatic accumulate_pixel(input mg3_pkg::pixel_t p);
    bit               last_tap;
    int               w;
    mg3_pkg::result_t blur;
    last_tap = (tap_pos >= 8);
    w = TAP_WEIGHT[last_tap ? 8 : tap_pos];
    red_acc   = mg3_pkg::SUM_W'(int'(red_acc) + int'(p.red_in) * w);
    green_acc = mg3_pkg::SUM_W'(int'(green_acc) + int'(p.green_in) * w);
    blue_acc  = mg3_pkg::SUM_W'(int'(blue_acc) + int'(p.blue_in) * w);
    if (p.red_in != 0 && p.green_in != 0 && p.blue_in != 0)
      counted_weight = mg3_pkg::TOT_W'(int'(counted_weight) + w);
    if (!last_tap) begin
      tap_pos = tap_pos + 1'b1;
    end else begin
      // No counted pixel: channels forced to zero, flag raised
      if (counted_weight == 0) begin
        blur.red_out = '0;
        blur.green_out = '0;
        blur.blue_out = '0;
        blur.zero_weight = 1'b1;
      end else begin
        blur.red_out = mg3_pkg::OUT_W'(int'(red_acc) / int'(counted_weight));
        blur.green_out = mg3_pkg::OUT_W'(int'(green_acc) / int'(counted_weight));
        blur.blue_out = mg3_pkg::OUT_W'(int'(blue_acc) / int'(counted_weight));
        blur.zero_weight = 1'b0;
      end
      expected_blurs.push_back(blur);
      clear_window();
    end
  endtask

  // Compare one result transaction with the oldest expected blur
  task automatic check_result(input mg3_pkg::result_t got);
    mg3_pkg::result_t want;
    if (expected_blurs.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: unexpected result r=%0d g=%0d b=%0d z=%0b", $realtime,
                 got.red_out, got.green_out, got.blue_out, got.zero_weight);
      return;
    end
    want = expected_blurs.pop_front();
    if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
        got.blue_out !== want.blue_out || got.zero_weight !== want.zero_weight) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("%0t: result mismatch exp r=%0d g=%0d b=%0d z=%0b got r=%0d g=%0d b=%0d z=%0b",
                 $realtime, want.red_out, want.green_out, want.blue_out, want.zero_weight,
                 got.red_out, got.green_out, got.blue_out, got.zero_weight);
    end
  endtask

  // Results are checked before the pixel of the same edge is folded in
  always @(posedge clk) begin
    if (rst) begin
      clear_window();
      expected_blurs.delete();
    end else begin
      if (res_valid && res_ready)
        check_result(res);
      if (pix_valid && pix_ready)
        accumulate_pixel(pix);
    end
    fail_count <= failures;
    pending <= expected_blurs.size();
  end

endmodule

/* verif/masked_gauss_3x3_rgb_top_tb.sv */
// Testbench top for the masked 3x3 Gaussian RGB blur: drives pixel windows with
// random gaps and result stalls, and gives the verdict.
// Depends on mg3_pkg, masked_gauss_3x3_rgb_top and masked_gauss_3x3_rgb_check.
module masked_gauss_3x3_rgb_top_tb;

  localparam int PIXEL_TARGET = 700;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 300;
  localparam int MAX_GAP = 13;

  logic             clk;
  logic             rst;
  logic             pix_valid;
  logic             pix_ready;
  mg3_pkg::pixel_t  pix;
  logic             res_valid;
  logic             res_ready;
  mg3_pkg::result_t res;
  int               fail_count;
  int               pending;

  mg3_pkg::pixel_t window_px [9];
  int              pixels_sent = 0;
  int              quiet_cycles = 0;

  masked_gauss_3x3_rgb_top dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  masked_gauss_3x3_rgb_check u_check (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one pixel after an optional gap and hold it until accepted
  task automatic send_pixel(input mg3_pkg::pixel_t p, input int gap);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (!pix_ready);
    pixels_sent++;
  endtask

  task automatic send_window(input bit no_gaps);
    for (int i = 0; i < 9; i++)
      send_pixel(window_px[i], no_gaps ? 0 : $urandom_range(0, MAX_GAP));
  endtask

  // Channel value with a given chance of zero, biased toward the extremes
  function automatic logic [mg3_pkg::PIXEL_BITS-1:0] draw_channel(input int zero_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < zero_pct)
      return '0;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      return '1;
    if (roll == 1)
      return mg3_pkg::PIXEL_BITS'(1);
    return mg3_pkg::PIXEL_BITS'($urandom_range(1, (1 << mg3_pkg::PIXEL_BITS) - 1));
  endfunction

  // Pixel stimulus and verdict
  initial begin
    int zero_pct;
    rst <= 1'b1;
    pix_valid <= 1'b0;
    pix <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Every channel at full scale
    foreach (window_px[i]) window_px[i] = '{blue_in: '1, green_in: '1, red_in: '1};
    send_window(1'b0);
    // Only the first corner counts: total of one, red and green reach 4080
    foreach (window_px[i]) window_px[i] = '{blue_in: '0, green_in: '1, red_in: '1};
    window_px[0] = '{blue_in: '1, green_in: '1, red_in: '1};
    send_window(1'b1);
    // Every pixel has one zero channel: nothing counted, zero-weight flag
    foreach (window_px[i]) begin
      window_px[i] = '{blue_in: 8'd200, green_in: 8'd128, red_in: 8'd77};
      case (i % 3)
        0: window_px[i].red_in = '0;
        1: window_px[i].green_in = '0;
        default: window_px[i].blue_in = '0;
      endcase
    end
    send_window(1'b0);

    // Random windows with varying density of zero channels
    while (pixels_sent < PIXEL_TARGET) begin
      case ($urandom_range(0, 3))
        0: zero_pct = 0;
        1: zero_pct = 5;
        2: zero_pct = 20;
        default: zero_pct = 60;
      endcase
      foreach (window_px[i]) begin
        window_px[i].red_in = draw_channel(zero_pct);
        window_px[i].green_in = draw_channel(zero_pct);
        window_px[i].blue_in = draw_channel(zero_pct);
      end
      send_window($urandom_range(0, 3) == 0);
    end
    pix_valid <= 1'b0;

    // Let the last window's result come out, then allow for stray output
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result receiver: random stalls, one long hold-off early in the run
  initial begin
    int hold;
    int taken;
    taken = 0;
    res_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken == 5)
        hold = LONG_HOLD;
      else if (taken % 16 < 4)
        hold = 0;
      else
        hold = $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        res_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      taken++;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
